@@ design/assert_macros.svh @@
// Assertion macros shared by the downscaler RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is held
`define BXDS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bxds assertion failed");
// Next-cycle implication, disabled while reset is held
`define BXDS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bxds assertion failed");
`else
`define BXDS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define BXDS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ design/bxds_pkg.sv @@
// Package for the box average downscaler: widths, register indexes, types.
// No dependencies; used by bxds_if, the top level, bxds_pos and bxds_div.
`timescale 1ns / 1ps

package bxds_pkg;

    // Default sizing of the line store and the largest block
    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_FACTOR_DEF = 16;
    localparam int HEIGHT_LIMIT   = 2048;

    // Field widths
    localparam int PIX_W       = 8;
    localparam int BLK_FIELD_W = 5;
    localparam int WID_FIELD_W = 12;
    localparam int HGT_FIELD_W = 12;
    localparam int HGT_W       = $clog2(HEIGHT_LIMIT + 1);
    localparam int ROW_W       = $clog2(HEIGHT_LIMIT);
    localparam int NUM_CHAN    = 3;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

    // Register reset values
    localparam int BLOCK_SIZE_RST   = 2;
    localparam int IMAGE_WIDTH_RST  = 640;
    localparam int IMAGE_HEIGHT_RST = 480;

    // Request sequencing
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RMW,
        ST_DIV,
        ST_HOLD
    } t_state;

    // Where the current pixel sits relative to its block
    typedef struct packed {
        logic in_block;
        logic first;
        logic last;
        logic row_end;
        logic frame_end;
    } t_blk_flags;

endpackage

@@ design/bxds_if.sv @@
// Handshake channels of the downscaler: pixels in, block averages out, register writes.
// Depends on bxds_pkg for field widths.
`timescale 1ns / 1ps

interface bxds_pix_if;
    logic                        valid;
    logic                        ready;
    logic [bxds_pkg::PIX_W-1:0]  red_in;
    logic [bxds_pkg::PIX_W-1:0]  green_in;
    logic [bxds_pkg::PIX_W-1:0]  blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink (input valid, input red_in, input green_in, input blue_in,
                  output ready);
endinterface

interface bxds_res_if;
    logic                        valid;
    logic                        ready;
    logic [bxds_pkg::PIX_W-1:0]  red_avg;
    logic [bxds_pkg::PIX_W-1:0]  green_avg;
    logic [bxds_pkg::PIX_W-1:0]  blue_avg;
    logic                        row_end;
    logic                        frame_end;

    modport source (output valid, output red_avg, output green_avg, output blue_avg,
                    output row_end, output frame_end, input ready);
    modport sink (input valid, input red_avg, input green_avg, input blue_avg,
                  input row_end, input frame_end, output ready);
endinterface

interface bxds_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [bxds_pkg::CFG_IDX_W-1:0]    index;
    logic [bxds_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/box_average_downscaler.sv @@
// Box average downscaler: top level with register bank, request sequencer and output stage.
// Depends on bxds_pkg, bxds_if, bxds_line_mem, bxds_pos, bxds_div and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// RGB pixels come in raster order; each complete block_size x block_size block gives one
// result, the truncated per-channel mean, on its bottom-right pixel. Partial blocks at the
// right and bottom edges are dropped. Block sums live in a line store with one entry per
// block column, read once per pixel and written back for pixels of complete blocks: a pixel
// is first read from memory, then added and written back; for the pixel that completes a
// block, its three sums then go through an 8-step shift-subtract divider before the result
// register is loaded. The next pixel is taken while a result waits in that register. The
// store needs no clearing after reset: the first pixel of each block overwrites its entry.
// Any register write restarts the frame; a write to an unknown index is ignored.
module box_average_downscaler #(
    parameter int MAX_WIDTH  = bxds_pkg::MAX_WIDTH_DEF,
    parameter int MAX_FACTOR = bxds_pkg::MAX_FACTOR_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    bxds_pix_if.sink        i_pix,
    bxds_res_if.source      o_res,
    bxds_cfg_if.sink        i_cfg
);

    localparam int BS_W    = $clog2(MAX_FACTOR + 1);
    localparam int FB_W    = $clog2(MAX_FACTOR);
    localparam int WID_W   = $clog2(MAX_WIDTH + 1);
    localparam int ADDR_W  = $clog2(MAX_WIDTH);
    localparam int AREA_W  = 2 * FB_W + 1;
    localparam int SUM_W   = bxds_pkg::PIX_W + 2 * FB_W;
    localparam int NCH     = bxds_pkg::NUM_CHAN;
    localparam int WID_RST = (bxds_pkg::IMAGE_WIDTH_RST > MAX_WIDTH)
                             ? MAX_WIDTH : bxds_pkg::IMAGE_WIDTH_RST;

    // ---------------- Register bank ----------------
    logic [BS_W-1:0]             r_block_size, n_block_size;
    logic [AREA_W-1:0]           r_area,       n_area;
    logic [WID_W-1:0]            r_image_width, n_image_width;
    logic [bxds_pkg::HGT_W-1:0]  r_image_height, n_image_height;
    logic                        cfg_wr;
    logic                        restart;

    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid && i_cfg.ready;
    assign restart     = cfg_wr && ((i_cfg.index == bxds_pkg::CFG_BLOCK_SIZE)
                                 || (i_cfg.index == bxds_pkg::CFG_IMAGE_WIDTH)
                                 || (i_cfg.index == bxds_pkg::CFG_IMAGE_HEIGHT));

    // Clamp written values into range; zero means one
    always_comb begin
        int bs_v;
        int wd_v;
        int ht_v;
        bs_v = int'(i_cfg.data[bxds_pkg::BLK_FIELD_W-1:0]);
        wd_v = int'(i_cfg.data[bxds_pkg::WID_FIELD_W-1:0]);
        ht_v = int'(i_cfg.data[bxds_pkg::HGT_FIELD_W-1:0]);
        if (bs_v < 1) begin
            bs_v = 1;
        end else if (bs_v > MAX_FACTOR) begin
            bs_v = MAX_FACTOR;
        end
        if (wd_v < 1) begin
            wd_v = 1;
        end else if (wd_v > MAX_WIDTH) begin
            wd_v = MAX_WIDTH;
        end
        if (ht_v < 1) begin
            ht_v = 1;
        end else if (ht_v > bxds_pkg::HEIGHT_LIMIT) begin
            ht_v = bxds_pkg::HEIGHT_LIMIT;
        end
        n_block_size   = BS_W'(bs_v);
        n_area         = AREA_W'(bs_v * bs_v);
        n_image_width  = WID_W'(wd_v);
        n_image_height = bxds_pkg::HGT_W'(ht_v);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size   <= BS_W'(bxds_pkg::BLOCK_SIZE_RST);
            r_area         <= AREA_W'(bxds_pkg::BLOCK_SIZE_RST * bxds_pkg::BLOCK_SIZE_RST);
            r_image_width  <= WID_W'(WID_RST);
            r_image_height <= bxds_pkg::HGT_W'(bxds_pkg::IMAGE_HEIGHT_RST);
        end else if (cfg_wr) begin
            case (i_cfg.index)
                bxds_pkg::CFG_BLOCK_SIZE: begin
                    r_block_size <= n_block_size;
                    r_area       <= n_area;
                end
                bxds_pkg::CFG_IMAGE_WIDTH: begin
                    r_image_width <= n_image_width;
                end
                bxds_pkg::CFG_IMAGE_HEIGHT: begin
                    r_image_height <= n_image_height;
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------- Sequencer ----------------
    bxds_pkg::t_state r_state, n_state;
    logic             pix_acc;
    logic             pix_ready;
    logic             mem_wr;
    logic             div_start;
    logic             out_load;
    logic             out_free;
    logic             div_done;

    bxds_pkg::t_blk_flags pos_flags;
    logic [ADDR_W-1:0]    pos_addr;

    bxds_pkg::t_blk_flags                  r_flags;
    logic [ADDR_W-1:0]                     r_addr;
    logic [NCH-1:0][bxds_pkg::PIX_W-1:0]   r_pix;

    logic                                  r_out_valid;
    logic [NCH-1:0][bxds_pkg::PIX_W-1:0]   r_avg;
    logic                                  r_row_end;
    logic                                  r_frame_end;

    assign pix_acc  = i_pix.valid && pix_ready;
    assign out_free = !r_out_valid || o_res.ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bxds_pkg::ST_IDLE: begin
                if (i_pix.valid) begin
                    n_state = bxds_pkg::ST_RMW;
                end
            end
            bxds_pkg::ST_RMW: begin
                if (r_flags.in_block && r_flags.last) begin
                    n_state = bxds_pkg::ST_DIV;
                end else begin
                    n_state = bxds_pkg::ST_IDLE;
                end
            end
            bxds_pkg::ST_DIV: begin
                if (div_done) begin
                    n_state = out_free ? bxds_pkg::ST_IDLE : bxds_pkg::ST_HOLD;
                end
            end
            bxds_pkg::ST_HOLD: begin
                if (out_free) begin
                    n_state = bxds_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bxds_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb begin
        pix_ready = 1'b0;
        mem_wr    = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            bxds_pkg::ST_IDLE: begin
                pix_ready = 1'b1;
            end
            bxds_pkg::ST_RMW: begin
                mem_wr    = r_flags.in_block;
                div_start = r_flags.in_block && r_flags.last;
            end
            bxds_pkg::ST_DIV: begin
                out_load = div_done && out_free;
            end
            bxds_pkg::ST_HOLD: begin
                out_load = out_free;
            end
            default: begin
            end
        endcase
    end

    assign i_pix.ready = pix_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bxds_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the request and its block position
    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_flags <= pos_flags;
            r_addr  <= pos_addr;
            r_pix   <= {i_pix.red_in, i_pix.green_in, i_pix.blue_in};
        end
    end

    // ---------------- Position tracker ----------------
    bxds_pos #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_pos (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_restart      (restart),
        .i_advance      (pix_acc),
        .i_block_size   (r_block_size),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .o_flags        (pos_flags),
        .o_addr         (pos_addr)
    );

    // ---------------- Line store read-modify-write ----------------
    logic [NCH*SUM_W-1:0]        mem_rd_data;
    logic [NCH-1:0][SUM_W-1:0]   old_sums;
    logic [NCH-1:0][SUM_W-1:0]   new_sums;

    assign old_sums = mem_rd_data;

    // First pixel of a block replaces the stale entry
    always_comb begin
        for (int ch = 0; ch < NCH; ch++) begin
            if (r_flags.first) begin
                new_sums[ch] = SUM_W'(r_pix[ch]);
            end else begin
                new_sums[ch] = old_sums[ch] + SUM_W'(r_pix[ch]);
            end
        end
    end

    bxds_line_mem #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (NCH * SUM_W)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (pix_acc),
        .i_rd_addr (pos_addr),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (mem_wr),
        .i_wr_addr (r_addr),
        .i_wr_data (new_sums)
    );

    // ---------------- Divide by block area ----------------
    logic [NCH-1:0][bxds_pkg::PIX_W-1:0] div_quots;

    bxds_div #(
        .SUM_W  (SUM_W),
        .AREA_W (AREA_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_area  (r_area),
        .i_sums  (new_sums),
        .o_done  (div_done),
        .o_quots (div_quots)
    );

    // ---------------- Result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_avg       <= div_quots;
            r_row_end   <= r_flags.row_end;
            r_frame_end <= r_flags.frame_end;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.red_avg   = r_avg[2];
    assign o_res.green_avg = r_avg[1];
    assign o_res.blue_avg  = r_avg[0];
    assign o_res.row_end   = r_row_end;
    assign o_res.frame_end = r_frame_end;

    // ---------------- Checks ----------------
    `BXDS_ASSERT_NXT(a_acc_to_rmw, i_clk, i_rst_n, pix_acc, r_state == bxds_pkg::ST_RMW)
    `BXDS_ASSERT_IMP(a_hold_full, i_clk, i_rst_n, r_state == bxds_pkg::ST_HOLD, r_out_valid)
    `BXDS_ASSERT_IMP(a_frame_row, i_clk, i_rst_n, r_out_valid && r_frame_end, r_row_end)

endmodule

@@ design/bxds_line_mem.sv @@
// Line store of per-column block sums: one write port, one registered read port.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module bxds_line_mem #(
    parameter int DEPTH  = 2048,
    parameter int DATA_W = 48,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, registered
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/bxds_pos.sv @@
// Raster position tracker: pixel, block and block-start counters for the frame.
// Depends on bxds_pkg for the flag struct and row widths.
`timescale 1ns / 1ps

module bxds_pos #(
    parameter int MAX_WIDTH  = bxds_pkg::MAX_WIDTH_DEF,
    parameter int MAX_FACTOR = bxds_pkg::MAX_FACTOR_DEF,
    localparam int BS_W   = $clog2(MAX_FACTOR + 1),
    localparam int FB_W   = $clog2(MAX_FACTOR),
    localparam int WID_W  = $clog2(MAX_WIDTH + 1),
    localparam int COL_W  = $clog2(MAX_WIDTH),
    localparam int CMP_W  = ((WID_W > BS_W) ? WID_W : BS_W) + 2,
    localparam int RCMP_W = ((bxds_pkg::HGT_W > BS_W) ? bxds_pkg::HGT_W : BS_W) + 2
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_restart,
    input  logic                        i_advance,
    input  logic [BS_W-1:0]             i_block_size,
    input  logic [WID_W-1:0]            i_image_width,
    input  logic [bxds_pkg::HGT_W-1:0]  i_image_height,
    output bxds_pkg::t_blk_flags        o_flags,
    output logic [COL_W-1:0]            o_addr
);

    logic [COL_W-1:0]          r_pix_col,   n_pix_col;
    logic [COL_W-1:0]          r_col_start, n_col_start;
    logic [COL_W-1:0]          r_out_col,   n_out_col;
    logic [FB_W-1:0]           r_col_blk,   n_col_blk;
    logic [bxds_pkg::ROW_W-1:0] r_pix_row,  n_pix_row;
    logic [bxds_pkg::ROW_W-1:0] r_row_start, n_row_start;
    logic [FB_W-1:0]           r_row_blk,   n_row_blk;

    logic col_last, row_last, cblk_last, rblk_last;
    logic in_col, in_row, last_blk_col, last_blk_row;

    // End-of-row, end-of-frame and end-of-block tests
    assign col_last  = (WID_W'(r_pix_col) + WID_W'(1)) >= i_image_width;
    assign row_last  = (bxds_pkg::HGT_W'(r_pix_row) + bxds_pkg::HGT_W'(1)) >= i_image_height;
    assign cblk_last = (BS_W'(r_col_blk) + BS_W'(1)) >= i_block_size;
    assign rblk_last = (BS_W'(r_row_blk) + BS_W'(1)) >= i_block_size;

    // Block completeness: the block fits when its start plus the side stays inside
    assign in_col = (CMP_W'(r_col_start) + CMP_W'(i_block_size)) <= CMP_W'(i_image_width);
    assign in_row = (RCMP_W'(r_row_start) + RCMP_W'(i_block_size))
                    <= RCMP_W'(i_image_height);
    assign last_blk_col = (CMP_W'(r_col_start) + CMP_W'(i_block_size)
                           + CMP_W'(i_block_size)) > CMP_W'(i_image_width);
    assign last_blk_row = (RCMP_W'(r_row_start) + RCMP_W'(i_block_size)
                           + RCMP_W'(i_block_size)) > RCMP_W'(i_image_height);

    always_comb begin
        o_flags.in_block  = in_col && in_row;
        o_flags.first     = (r_col_blk == '0) && (r_row_blk == '0);
        o_flags.last      = cblk_last && rblk_last;
        o_flags.row_end   = last_blk_col;
        o_flags.frame_end = last_blk_col && last_blk_row;
    end

    assign o_addr = r_out_col;

    // Raster advance
    always_comb begin
        n_pix_col   = r_pix_col;
        n_col_start = r_col_start;
        n_out_col   = r_out_col;
        n_col_blk   = r_col_blk;
        n_pix_row   = r_pix_row;
        n_row_start = r_row_start;
        n_row_blk   = r_row_blk;
        if (i_restart) begin
            n_pix_col   = '0;
            n_col_start = '0;
            n_out_col   = '0;
            n_col_blk   = '0;
            n_pix_row   = '0;
            n_row_start = '0;
            n_row_blk   = '0;
        end else if (i_advance) begin
            if (col_last) begin
                n_pix_col   = '0;
                n_col_start = '0;
                n_out_col   = '0;
                n_col_blk   = '0;
                if (row_last) begin
                    n_pix_row   = '0;
                    n_row_start = '0;
                    n_row_blk   = '0;
                end else begin
                    n_pix_row = r_pix_row + bxds_pkg::ROW_W'(1);
                    if (rblk_last) begin
                        n_row_blk   = '0;
                        n_row_start = bxds_pkg::ROW_W'(RCMP_W'(r_row_start)
                                                       + RCMP_W'(i_block_size));
                    end else begin
                        n_row_blk = r_row_blk + FB_W'(1);
                    end
                end
            end else begin
                n_pix_col = r_pix_col + COL_W'(1);
                if (cblk_last) begin
                    n_col_blk   = '0;
                    n_out_col   = r_out_col + COL_W'(1);
                    n_col_start = COL_W'(CMP_W'(r_col_start) + CMP_W'(i_block_size));
                end else begin
                    n_col_blk = r_col_blk + FB_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_col   <= '0;
            r_col_start <= '0;
            r_out_col   <= '0;
            r_col_blk   <= '0;
            r_pix_row   <= '0;
            r_row_start <= '0;
            r_row_blk   <= '0;
        end else begin
            r_pix_col   <= n_pix_col;
            r_col_start <= n_col_start;
            r_out_col   <= n_out_col;
            r_col_blk   <= n_col_blk;
            r_pix_row   <= n_pix_row;
            r_row_start <= n_row_start;
            r_row_blk   <= n_row_blk;
        end
    end

endmodule

@@ design/bxds_div.sv @@
// Iterative divider: three channel sums by the block area, one quotient bit a cycle.
// Depends on bxds_pkg for the pixel width and channel count.
`timescale 1ns / 1ps

module bxds_div #(
    parameter int SUM_W  = 16,
    parameter int AREA_W = 9,
    localparam int CNT_W = $clog2(bxds_pkg::PIX_W)
) (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  logic                                                i_start,
    input  logic [AREA_W-1:0]                                   i_area,
    input  logic [bxds_pkg::NUM_CHAN-1:0][SUM_W-1:0]            i_sums,
    output logic                                                o_done,
    output logic [bxds_pkg::NUM_CHAN-1:0][bxds_pkg::PIX_W-1:0]  o_quots
);

    logic [bxds_pkg::NUM_CHAN-1:0][SUM_W-1:0]           r_rem;
    logic [bxds_pkg::NUM_CHAN-1:0][bxds_pkg::PIX_W-1:0] r_quot;
    logic [SUM_W-1:0]                                   r_dvs;
    logic [CNT_W-1:0]                                   r_cnt;
    logic                                               r_busy;
    logic                                               r_done;

    // Control: count the quotient bits, flag completion
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(bxds_pkg::PIX_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Restoring steps: quotient fits the pixel width, so the divisor starts shifted by one less
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_sums;
            r_quot <= '0;
            r_dvs  <= SUM_W'(i_area) << (bxds_pkg::PIX_W - 1);
        end else if (r_busy) begin
            for (int ch = 0; ch < bxds_pkg::NUM_CHAN; ch++) begin
                if (r_rem[ch] >= r_dvs) begin
                    r_rem[ch]  <= r_rem[ch] - r_dvs;
                    r_quot[ch] <= {r_quot[ch][bxds_pkg::PIX_W-2:0], 1'b1};
                end else begin
                    r_quot[ch] <= {r_quot[ch][bxds_pkg::PIX_W-2:0], 1'b0};
                end
            end
            r_dvs <= r_dvs >> 1;
        end
    end

    assign o_done  = r_done;
    assign o_quots = r_quot;

endmodule
